FILE: hdl/i2cm_pkg.sv
// ----------------------------------------------------------------------------
// i2cm_pkg
// Shared codes, widths and the result record of the I2C master bit sequencer.
// ----------------------------------------------------------------------------
package i2cm_pkg;

    localparam int unsigned PHASE_W = 5;
    localparam int unsigned TPU_W   = 16;
    localparam int unsigned TMO_W   = 8;
    localparam int unsigned CFG_W   = 16;

    // command opcodes
    localparam logic [2:0] OP_TICK  = 3'd0;
    localparam logic [2:0] OP_START = 3'd1;
    localparam logic [2:0] OP_STOP  = 3'd2;
    localparam logic [2:0] OP_WRITE = 3'd3;
    localparam logic [2:0] OP_READ  = 3'd4;
    localparam logic [2:0] OP_WAIT  = 3'd5;
    localparam logic [2:0] OP_CHECK = 3'd6;
    localparam logic [2:0] OP_RSVD  = 3'd7;

    // configuration register indexes
    localparam logic CFG_TICKS_PER_UNIT = 1'b0;
    localparam logic CFG_ACK_TIMEOUT    = 1'b1;

    localparam logic [TPU_W-1:0] TPU_RESET = 16'd10;
    localparam logic [TMO_W-1:0] TMO_RESET = 8'd250;

    // sequencer phases
    localparam logic [PHASE_W-1:0] PH_IDLE = 5'd0;
    localparam logic [PHASE_W-1:0] PH_ST_A = 5'd1;
    localparam logic [PHASE_W-1:0] PH_ST_B = 5'd2;
    localparam logic [PHASE_W-1:0] PH_SP_A = 5'd3;
    localparam logic [PHASE_W-1:0] PH_SP_B = 5'd4;
    localparam logic [PHASE_W-1:0] PH_WR_A = 5'd5;
    localparam logic [PHASE_W-1:0] PH_WR_B = 5'd6;
    localparam logic [PHASE_W-1:0] PH_WR_C = 5'd7;
    localparam logic [PHASE_W-1:0] PH_RD_A = 5'd8;
    localparam logic [PHASE_W-1:0] PH_RD_B = 5'd9;
    localparam logic [PHASE_W-1:0] PH_AK_A = 5'd10;
    localparam logic [PHASE_W-1:0] PH_AK_B = 5'd11;
    localparam logic [PHASE_W-1:0] PH_WA_A = 5'd12;
    localparam logic [PHASE_W-1:0] PH_WA_B = 5'd13;
    localparam logic [PHASE_W-1:0] PH_POLL = 5'd14;
    localparam logic [PHASE_W-1:0] PH_SX_A = 5'd15;
    localparam logic [PHASE_W-1:0] PH_SX_B = 5'd16;

    typedef struct packed {
        logic       scl_level;
        logic       sda_level;
        logic       sda_enable;
        logic       busy_res;
        logic       done_res;
        logic [7:0] rx_byte;
        logic       ack_fail;
        logic       refused;
    } i2cm_result_t;

endpackage

FILE: hdl/i2cm_core.sv
// ----------------------------------------------------------------------------
// i2cm_core
// Sequencer state, configuration registers and the one-item step logic.
// ----------------------------------------------------------------------------
module i2cm_core
    import i2cm_pkg::*;
(
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                cfg_we,
    input  logic                cfg_index,
    input  logic [CFG_W-1:0]    cfg_data,
    input  logic                step_en,
    input  logic [2:0]          opcode,
    input  logic [7:0]          tx_byte,
    input  logic                send_ack,
    input  logic                sda_sample,
    output i2cm_result_t        result
);

    logic [TPU_W-1:0]   tpu_reg;
    logic [TMO_W-1:0]   tmo_reg;

    logic [PHASE_W-1:0] phase_reg, phase_next;
    logic [2:0]         cmd_reg, cmd_next;
    logic [3:0]         bit_reg, bit_next;
    logic [7:0]         shift_reg, shift_next;
    logic [TPU_W-1:0]   ticks_reg, ticks_next;
    logic [2:0]         units_reg, units_next;
    logic [TMO_W-1:0]   poll_reg, poll_next;
    logic               ack_choice_reg, ack_choice_next;
    logic               scl_reg, scl_next;
    logic               sda_reg, sda_next;
    logic               sda_en_reg, sda_en_next;
    logic [7:0]         last_rx_reg, last_rx_next;
    logic               ack_err_reg, ack_err_next;

    logic               finished;
    logic               refused;
    logic [TPU_W-1:0]   tpu;
    logic [TPU_W-1:0]   ticks_inc;
    logic [2:0]         units_dec;
    logic [3:0]         bit_inc;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            tpu_reg <= TPU_RESET;
            tmo_reg <= TMO_RESET;
        end else if (cfg_we) begin
            if (cfg_index == CFG_TICKS_PER_UNIT) begin
                tpu_reg <= cfg_data;
            end else begin
                tmo_reg <= cfg_data[TMO_W-1:0];
            end
        end
    end

    always_comb begin
        phase_next      = phase_reg;
        cmd_next        = cmd_reg;
        bit_next        = bit_reg;
        shift_next      = shift_reg;
        ticks_next      = ticks_reg;
        units_next      = units_reg;
        poll_next       = poll_reg;
        ack_choice_next = ack_choice_reg;
        scl_next        = scl_reg;
        sda_next        = sda_reg;
        sda_en_next     = sda_en_reg;
        last_rx_next    = last_rx_reg;
        ack_err_next    = ack_err_reg;
        finished        = 1'b0;
        refused         = 1'b0;

        tpu       = (tpu_reg == '0) ? {{(TPU_W-1){1'b0}}, 1'b1} : tpu_reg;
        ticks_inc = ticks_reg + {{(TPU_W-1){1'b0}}, 1'b1};
        units_dec = (units_reg != 3'd0) ? units_reg - 3'd1 : 3'd0;
        bit_inc   = bit_reg + 4'd1;

        if (step_en) begin
            if (opcode == OP_TICK) begin
                if (phase_reg == PH_IDLE) begin
                    // nothing to advance
                end else if (phase_reg == PH_POLL) begin
                    if (!sda_sample) begin
                        scl_next = 1'b0;
                        if (cmd_reg == OP_CHECK) begin
                            sda_en_next = 1'b1; scl_next = 1'b0; sda_next = 1'b0;
                            phase_next = PH_SP_A; units_next = 3'd4; ticks_next = '0;
                        end else begin
                            phase_next = PH_IDLE; units_next = 3'd0; ticks_next = '0;
                            finished = 1'b1;
                        end
                    end else if (poll_reg >= tmo_reg) begin
                        // timed out: flag and release the bus with a stop
                        ack_err_next = 1'b1;
                        sda_en_next = 1'b1; scl_next = 1'b0; sda_next = 1'b0;
                        phase_next = PH_SX_A; units_next = 3'd4; ticks_next = '0;
                    end else begin
                        poll_next = poll_reg + 8'd1;
                    end
                end else begin
                    ticks_next = ticks_inc;
                    if (ticks_inc >= tpu) begin
                        ticks_next = '0;
                        units_next = units_dec;
                        if (units_dec == 3'd0) begin
                            case (phase_reg)
                                PH_ST_A: begin
                                    sda_next = 1'b0;
                                    phase_next = PH_ST_B; units_next = 3'd4;
                                end
                                PH_ST_B: begin
                                    scl_next = 1'b0;
                                    if (cmd_reg == OP_CHECK) begin
                                        sda_en_next = 1'b1;
                                        bit_next = 4'd0;
                                        sda_next = shift_reg[7];
                                        phase_next = PH_WR_A; units_next = 3'd2;
                                    end else begin
                                        phase_next = PH_IDLE; units_next = 3'd0;
                                        finished = 1'b1;
                                    end
                                end
                                PH_SP_A, PH_SX_A: begin
                                    scl_next = 1'b1; sda_next = 1'b1;
                                    phase_next = (phase_reg == PH_SP_A) ? PH_SP_B : PH_SX_B;
                                    units_next = 3'd4;
                                end
                                PH_SX_B: begin
                                    if (cmd_reg == OP_CHECK) begin
                                        sda_en_next = 1'b1; scl_next = 1'b0; sda_next = 1'b0;
                                        phase_next = PH_SP_A; units_next = 3'd4;
                                    end else begin
                                        phase_next = PH_IDLE; units_next = 3'd0;
                                        finished = 1'b1;
                                    end
                                end
                                PH_WR_A: begin
                                    scl_next = 1'b1;
                                    phase_next = PH_WR_B; units_next = 3'd2;
                                end
                                PH_WR_B: begin
                                    scl_next = 1'b0;
                                    if (bit_reg == 4'd7) begin
                                        sda_next = 1'b1;
                                    end
                                    shift_next = {shift_reg[6:0], 1'b0};
                                    phase_next = PH_WR_C; units_next = 3'd2;
                                end
                                PH_WR_C: begin
                                    bit_next = bit_inc;
                                    if (bit_inc < 4'd8) begin
                                        sda_next = shift_reg[7];
                                        phase_next = PH_WR_A; units_next = 3'd2;
                                    end else if (cmd_reg == OP_CHECK) begin
                                        sda_en_next = 1'b0; scl_next = 1'b1;
                                        phase_next = PH_WA_A; units_next = 3'd1;
                                    end else begin
                                        phase_next = PH_IDLE; units_next = 3'd0;
                                        finished = 1'b1;
                                    end
                                end
                                PH_RD_A: begin
                                    scl_next = 1'b1;
                                    phase_next = PH_RD_B; units_next = 3'd1;
                                end
                                PH_RD_B: begin
                                    // take the data bit on the last tick of SCL high
                                    shift_next = {shift_reg[6:0], sda_sample};
                                    bit_next = bit_inc;
                                    scl_next = 1'b0;
                                    if (bit_inc < 4'd8) begin
                                        phase_next = PH_RD_A; units_next = 3'd2;
                                    end else begin
                                        sda_en_next = 1'b1;
                                        sda_next = !ack_choice_reg;
                                        phase_next = PH_AK_A; units_next = 3'd2;
                                    end
                                end
                                PH_AK_A: begin
                                    scl_next = 1'b1;
                                    phase_next = PH_AK_B; units_next = 3'd2;
                                end
                                PH_AK_B: begin
                                    scl_next = 1'b0;
                                    last_rx_next = shift_reg;
                                    phase_next = PH_IDLE; units_next = 3'd0;
                                    finished = 1'b1;
                                end
                                PH_WA_A: begin
                                    sda_next = 1'b1;
                                    phase_next = PH_WA_B; units_next = 3'd1;
                                end
                                PH_WA_B: begin
                                    poll_next = '0;
                                    phase_next = PH_POLL; units_next = 3'd0;
                                end
                                default: begin
                                    phase_next = PH_IDLE; units_next = 3'd0;
                                    finished = 1'b1;
                                end
                            endcase
                        end
                    end
                end
            end else if (opcode != OP_RSVD) begin
                if (phase_reg != PH_IDLE) begin
                    refused = 1'b1;
                end else begin
                    cmd_next     = opcode;
                    ack_err_next = 1'b0;
                    ticks_next   = '0;
                    case (opcode)
                        OP_START: begin
                            sda_en_next = 1'b1; scl_next = 1'b1; sda_next = 1'b1;
                            phase_next = PH_ST_A; units_next = 3'd4;
                        end
                        OP_STOP: begin
                            sda_en_next = 1'b1; scl_next = 1'b0; sda_next = 1'b0;
                            phase_next = PH_SP_A; units_next = 3'd4;
                        end
                        OP_WRITE: begin
                            sda_en_next = 1'b1; scl_next = 1'b0;
                            shift_next = tx_byte;
                            bit_next = 4'd0;
                            sda_next = tx_byte[7];
                            phase_next = PH_WR_A; units_next = 3'd2;
                        end
                        OP_READ: begin
                            ack_choice_next = send_ack;
                            sda_en_next = 1'b0;
                            shift_next = 8'd0;
                            bit_next = 4'd0;
                            scl_next = 1'b0;
                            phase_next = PH_RD_A; units_next = 3'd2;
                        end
                        OP_WAIT: begin
                            sda_en_next = 1'b0; scl_next = 1'b1;
                            phase_next = PH_WA_A; units_next = 3'd1;
                        end
                        default: begin
                            // check device: address with the R/W bit cleared
                            shift_next = {tx_byte[7:1], 1'b0};
                            sda_en_next = 1'b1; scl_next = 1'b1; sda_next = 1'b1;
                            phase_next = PH_ST_A; units_next = 3'd4;
                        end
                    endcase
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg      <= PH_IDLE;
            cmd_reg        <= 3'd0;
            bit_reg        <= 4'd0;
            shift_reg      <= 8'd0;
            ticks_reg      <= '0;
            units_reg      <= 3'd0;
            poll_reg       <= '0;
            ack_choice_reg <= 1'b0;
            scl_reg        <= 1'b1;
            sda_reg        <= 1'b1;
            sda_en_reg     <= 1'b1;
            last_rx_reg    <= 8'd0;
            ack_err_reg    <= 1'b0;
        end else begin
            phase_reg      <= phase_next;
            cmd_reg        <= cmd_next;
            bit_reg        <= bit_next;
            shift_reg      <= shift_next;
            ticks_reg      <= ticks_next;
            units_reg      <= units_next;
            poll_reg       <= poll_next;
            ack_choice_reg <= ack_choice_next;
            scl_reg        <= scl_next;
            sda_reg        <= sda_next;
            sda_en_reg     <= sda_en_next;
            last_rx_reg    <= last_rx_next;
            ack_err_reg    <= ack_err_next;
        end
    end

    always_comb begin
        result.scl_level  = scl_next;
        result.sda_level  = sda_next;
        result.sda_enable = sda_en_next;
        result.busy_res   = (phase_next != PH_IDLE);
        result.done_res   = finished;
        result.rx_byte    = last_rx_next;
        result.ack_fail   = finished & ack_err_next;
        result.refused    = refused;
    end

endmodule

FILE: hdl/i2c_master_bit_sequencer.sv
// ----------------------------------------------------------------------------
// i2c_master_bit_sequencer
// I2C master that sequences SCL/SDA levels one command or tick at a time.
// An accepted item is registered in the input register, then passes through the
// step logic into the result register.
// Throughput: one item per cycle while results are taken.
// Reset: synchronous, active low; returns to idle with SCL, SDA and the
// SDA enable high, ticks_per_unit 10 and ack_timeout 250.
// ----------------------------------------------------------------------------
module i2c_master_bit_sequencer
    import i2cm_pkg::*;
(
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                cfg_we,
    input  logic                cfg_index,
    input  logic [CFG_W-1:0]    cfg_data,
    input  logic                s_valid,
    output logic                s_ready,
    input  logic [2:0]          s_opcode,
    input  logic [7:0]          s_tx_byte,
    input  logic                s_send_ack,
    input  logic                s_sda_sample,
    output logic                m_valid,
    input  logic                m_ready,
    output logic                m_scl_level,
    output logic                m_sda_level,
    output logic                m_sda_enable,
    output logic                m_busy_res,
    output logic                m_done_res,
    output logic [7:0]          m_rx_byte,
    output logic                m_ack_fail,
    output logic                m_refused
);

    logic         in_valid_reg;
    logic [2:0]   opcode_reg;
    logic [7:0]   tx_byte_reg;
    logic         send_ack_reg;
    logic         sample_reg;
    logic         out_valid_reg;
    i2cm_result_t res_reg;
    i2cm_result_t res_next;
    logic         advance;

    assign advance = in_valid_reg && (!out_valid_reg || m_ready);
    assign s_ready = !in_valid_reg || advance;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            if (s_ready) begin
                in_valid_reg <= s_valid;
            end
            if (advance) begin
                out_valid_reg <= 1'b1;
            end else if (m_ready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            opcode_reg   <= s_opcode;
            tx_byte_reg  <= s_tx_byte;
            send_ack_reg <= s_send_ack;
            sample_reg   <= s_sda_sample;
        end
        if (advance) begin
            res_reg <= res_next;
        end
    end

    i2cm_core u_core (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .cfg_we     (cfg_we),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .step_en    (advance),
        .opcode     (opcode_reg),
        .tx_byte    (tx_byte_reg),
        .send_ack   (send_ack_reg),
        .sda_sample (sample_reg),
        .result     (res_next)
    );

    assign m_valid      = out_valid_reg;
    assign m_scl_level  = res_reg.scl_level;
    assign m_sda_level  = res_reg.sda_level;
    assign m_sda_enable = res_reg.sda_enable;
    assign m_busy_res   = res_reg.busy_res;
    assign m_done_res   = res_reg.done_res;
    assign m_rx_byte    = res_reg.rx_byte;
    assign m_ack_fail   = res_reg.ack_fail;
    assign m_refused    = res_reg.refused;

endmodule

FILE: verif/i2c_master_bit_sequencer_checker.sv
// ----------------------------------------------------------------------------
// i2c_master_bit_sequencer_checker
// Watches both channels of the I2C bit sequencer. Every accepted input
// transaction is run through a local model of the bus sequencer, and the
// predicted pin state is queued. Each accepted result is compared field by
// field against the oldest prediction.
// ----------------------------------------------------------------------------
module i2c_master_bit_sequencer_checker
    import i2cm_pkg::*;
(
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                cfg_we,
    input  logic                cfg_index,
    input  logic [CFG_W-1:0]    cfg_data,
    input  logic                s_valid,
    input  logic                s_ready,
    input  logic [2:0]          s_opcode,
    input  logic [7:0]          s_tx_byte,
    input  logic                s_send_ack,
    input  logic                s_sda_sample,
    input  logic                m_valid,
    input  logic                m_ready,
    input  logic                m_scl_level,
    input  logic                m_sda_level,
    input  logic                m_sda_enable,
    input  logic                m_busy_res,
    input  logic                m_done_res,
    input  logic [7:0]          m_rx_byte,
    input  logic                m_ack_fail,
    input  logic                m_refused,
    output int                  fail_count,
    output int                  pending_count
);
    timeunit 1ns;
    timeprecision 1ps;

    logic [TPU_W-1:0]   tpu_cfg;
    logic [TMO_W-1:0]   tmo_cfg;
    logic [PHASE_W-1:0] seq_phase;
    logic [2:0]         seq_cmd;
    logic [3:0]         bit_cnt;
    logic [7:0]         shifter;
    logic [15:0]        tick_cnt;
    logic [2:0]         units_left;
    logic [7:0]         poll_cnt;
    logic               ack_sel;
    logic               scl_q;
    logic               sda_q;
    logic               sda_en_q;
    logic [7:0]         rx_last;
    logic               ack_err;
    logic               seq_done;

    i2cm_result_t       bus_expect_q[$];
    i2cm_result_t       want_res;

    initial begin
        fail_count = 0;
        pending_count = 0;
    end

    task automatic report_mismatch(input string what, input logic [7:0] want,
                                   input logic [7:0] seen);
        fail_count++;
        if (fail_count <= 40) begin
            $display("[%0t] %s: expected 0x%02h, got 0x%02h", $time, what, want, seen);
        end
    endtask

    task automatic compare_field(input string fld, input logic [7:0] want,
                                 input logic [7:0] seen);
        if (seen !== want) begin
            report_mismatch({"field ", fld}, want, seen);
        end
    endtask

    function automatic void enter_phase(input logic [PHASE_W-1:0] ph, input logic [2:0] n);
        seq_phase = ph;
        units_left = n;
        tick_cnt = '0;
    endfunction

    function automatic void end_sequence();
        seq_phase = PH_IDLE;
        units_left = '0;
        tick_cnt = '0;
        seq_done = 1'b1;
    endfunction

    function automatic void start_cond();
        sda_en_q = 1'b1;
        scl_q = 1'b1;
        sda_q = 1'b1;
        enter_phase(PH_ST_A, 3'd4);
    endfunction

    function automatic void stop_cond(input logic [PHASE_W-1:0] ph);
        sda_en_q = 1'b1;
        scl_q = 1'b0;
        sda_q = 1'b0;
        enter_phase(ph, 3'd4);
    endfunction

    function automatic void put_data_bit();
        sda_q = shifter[7];
        enter_phase(PH_WR_A, 3'd2);
    endfunction

    function automatic void load_write(input logic [7:0] b);
        sda_en_q = 1'b1;
        scl_q = 1'b0;
        shifter = b;
        bit_cnt = '0;
        put_data_bit();
    endfunction

    function automatic void next_read_bit();
        scl_q = 1'b0;
        enter_phase(PH_RD_A, 3'd2);
    endfunction

    function automatic void release_for_ack();
        sda_en_q = 1'b0;
        scl_q = 1'b1;
        enter_phase(PH_WA_A, 3'd1);
    endfunction

    // One input transaction in, the pin state it leaves behind out.
    function automatic i2cm_result_t predict_bus_step(input logic [2:0] op,
                                                      input logic [7:0] tx,
                                                      input logic ack,
                                                      input logic smp);
        i2cm_result_t r;
        logic         refuse;
        logic [15:0]  tpu;
        refuse = 1'b0;
        seq_done = 1'b0;
        tpu = (tpu_cfg == '0) ? 16'd1 : tpu_cfg;
        if (op == OP_TICK) begin
            if (seq_phase == PH_POLL) begin
                // one SDA sample per tick while SCL is high
                if (!smp) begin
                    scl_q = 1'b0;
                    if (seq_cmd == OP_CHECK) stop_cond(PH_SP_A);
                    else end_sequence();
                end else if (poll_cnt >= tmo_cfg) begin
                    ack_err = 1'b1;
                    stop_cond(PH_SX_A);
                end else begin
                    poll_cnt = poll_cnt + 8'd1;
                end
            end else if (seq_phase != PH_IDLE) begin
                tick_cnt = tick_cnt + 16'd1;
                if (tick_cnt >= tpu) begin
                    tick_cnt = '0;
                    if (units_left != '0) units_left = units_left - 3'd1;
                    if (units_left == '0) begin
                        case (seq_phase)
                            PH_ST_A: begin
                                sda_q = 1'b0;
                                enter_phase(PH_ST_B, 3'd4);
                            end
                            PH_ST_B: begin
                                scl_q = 1'b0;
                                if (seq_cmd == OP_CHECK) load_write(shifter);
                                else end_sequence();
                            end
                            PH_SP_A, PH_SX_A: begin
                                scl_q = 1'b1;
                                sda_q = 1'b1;
                                enter_phase((seq_phase == PH_SP_A) ? PH_SP_B : PH_SX_B, 3'd4);
                            end
                            PH_SP_B: end_sequence();
                            PH_SX_B: begin
                                // after a timeout stop, check device still runs its own stop
                                if (seq_cmd == OP_CHECK) stop_cond(PH_SP_A);
                                else end_sequence();
                            end
                            PH_WR_A: begin
                                scl_q = 1'b1;
                                enter_phase(PH_WR_B, 3'd2);
                            end
                            PH_WR_B: begin
                                scl_q = 1'b0;
                                if (bit_cnt == 4'd7) sda_q = 1'b1;
                                shifter = {shifter[6:0], 1'b0};
                                enter_phase(PH_WR_C, 3'd2);
                            end
                            PH_WR_C: begin
                                bit_cnt = bit_cnt + 4'd1;
                                if (bit_cnt < 4'd8) put_data_bit();
                                else if (seq_cmd == OP_CHECK) release_for_ack();
                                else end_sequence();
                            end
                            PH_RD_A: begin
                                scl_q = 1'b1;
                                enter_phase(PH_RD_B, 3'd1);
                            end
                            PH_RD_B: begin
                                // data bit comes from the last tick of the SCL-high unit
                                shifter = {shifter[6:0], smp};
                                bit_cnt = bit_cnt + 4'd1;
                                if (bit_cnt < 4'd8) begin
                                    next_read_bit();
                                end else begin
                                    scl_q = 1'b0;
                                    sda_en_q = 1'b1;
                                    sda_q = ~ack_sel;
                                    enter_phase(PH_AK_A, 3'd2);
                                end
                            end
                            PH_AK_A: begin
                                scl_q = 1'b1;
                                enter_phase(PH_AK_B, 3'd2);
                            end
                            PH_AK_B: begin
                                scl_q = 1'b0;
                                rx_last = shifter;
                                end_sequence();
                            end
                            PH_WA_A: begin
                                sda_q = 1'b1;
                                enter_phase(PH_WA_B, 3'd1);
                            end
                            PH_WA_B: begin
                                poll_cnt = '0;
                                enter_phase(PH_POLL, 3'd0);
                            end
                            default: end_sequence();
                        endcase
                    end
                end
            end
        end else if (op != OP_RSVD) begin
            if (seq_phase != PH_IDLE) begin
                refuse = 1'b1;
            end else begin
                seq_cmd = op;
                ack_err = 1'b0;
                case (op)
                    OP_START: start_cond();
                    OP_STOP:  stop_cond(PH_SP_A);
                    OP_WRITE: load_write(tx);
                    OP_READ: begin
                        ack_sel = ack;
                        sda_en_q = 1'b0;
                        shifter = '0;
                        bit_cnt = '0;
                        next_read_bit();
                    end
                    OP_WAIT:  release_for_ack();
                    default: begin
                        // address with the R/W bit forced to write
                        shifter = tx & 8'hFE;
                        start_cond();
                    end
                endcase
            end
        end
        r.scl_level  = scl_q;
        r.sda_level  = sda_q;
        r.sda_enable = sda_en_q;
        r.busy_res   = (seq_phase != PH_IDLE);
        r.done_res   = seq_done;
        r.rx_byte    = rx_last;
        r.ack_fail   = seq_done & ack_err;
        r.refused    = refuse;
        return r;
    endfunction

    always @(posedge aclk) begin
        if (!aresetn) begin
            tpu_cfg    = TPU_RESET;
            tmo_cfg    = TMO_RESET;
            seq_phase  = PH_IDLE;
            seq_cmd    = '0;
            bit_cnt    = '0;
            shifter    = '0;
            tick_cnt   = '0;
            units_left = '0;
            poll_cnt   = '0;
            ack_sel    = 1'b0;
            scl_q      = 1'b1;
            sda_q      = 1'b1;
            sda_en_q   = 1'b1;
            rx_last    = '0;
            ack_err    = 1'b0;
            seq_done   = 1'b0;
            bus_expect_q.delete();
        end else begin
            if (cfg_we) begin
                if (cfg_index == CFG_TICKS_PER_UNIT) tpu_cfg = cfg_data[TPU_W-1:0];
                else tmo_cfg = cfg_data[TMO_W-1:0];
            end
            if (m_valid && m_ready) begin
                if (bus_expect_q.size() == 0) begin
                    report_mismatch("result with nothing expected", 8'h00, 8'h00);
                end else begin
                    want_res = bus_expect_q.pop_front();
                    compare_field("scl_level", 8'(want_res.scl_level), 8'(m_scl_level));
                    compare_field("sda_level", 8'(want_res.sda_level), 8'(m_sda_level));
                    compare_field("sda_enable", 8'(want_res.sda_enable), 8'(m_sda_enable));
                    compare_field("busy_res", 8'(want_res.busy_res), 8'(m_busy_res));
                    compare_field("done_res", 8'(want_res.done_res), 8'(m_done_res));
                    compare_field("rx_byte", want_res.rx_byte, m_rx_byte);
                    compare_field("ack_fail", 8'(want_res.ack_fail), 8'(m_ack_fail));
                    compare_field("refused", 8'(want_res.refused), 8'(m_refused));
                end
            end
            if (s_valid && s_ready) begin
                bus_expect_q.push_back(predict_bus_step(s_opcode, s_tx_byte,
                                                        s_send_ack, s_sda_sample));
            end
        end
        pending_count = bus_expect_q.size();
    end

endmodule

FILE: verif/tb_i2c_master_bit_sequencer.sv
// ----------------------------------------------------------------------------
// tb_i2c_master_bit_sequencer
// Drives commands and SDA-sample ticks into the I2C bit sequencer under
// several unit lengths and acknowledge timeouts, with random stalls on both
// channels, and reports the verdict from the checker's failure and pending counts.
// ----------------------------------------------------------------------------
module tb_i2c_master_bit_sequencer;
    timeunit 1ns;
    timeprecision 1ps;

    import i2cm_pkg::*;

    logic               aclk;
    logic               aresetn;
    logic               cfg_we;
    logic               cfg_index;
    logic [CFG_W-1:0]   cfg_data;
    logic               s_valid;
    logic               s_ready;
    logic [2:0]         s_opcode;
    logic [7:0]         s_tx_byte;
    logic               s_send_ack;
    logic               s_sda_sample;
    logic               m_valid;
    logic               m_ready;
    logic               m_scl_level;
    logic               m_sda_level;
    logic               m_sda_enable;
    logic               m_busy_res;
    logic               m_done_res;
    logic [7:0]         m_rx_byte;
    logic               m_ack_fail;
    logic               m_refused;

    int                 fail_count;
    int                 pending_count;

    int unsigned        send_gap_max = 15;
    int unsigned        recv_gap_max = 15;
    int unsigned        rx_hold_len = 0;
    logic               rx_holding;
    logic               last_busy;
    int                 work_items = 0;

    i2c_master_bit_sequencer u_dut (.*);

    i2c_master_bit_sequencer_checker u_checker (.*);

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    initial begin
        #20_000_000;
        $display("RESULT: ERROR");
        $finish;
    end

    // Returns at the falling edge after acceptance with valid still high.
    task automatic send_item(input logic [2:0] op, input logic [7:0] tx,
                             input logic ack, input logic smp);
        int unsigned gap;
        gap = $urandom_range(0, send_gap_max);
        if ((op != OP_TICK && op != OP_RSVD) || pending_count != 0 || last_busy) begin
            work_items++;
        end
        if (gap != 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(negedge aclk);
        end
        s_opcode     <= op;
        s_tx_byte    <= tx;
        s_send_ack   <= ack;
        s_sda_sample <= smp;
        s_valid      <= 1'b1;
        do @(posedge aclk); while (!s_ready);
        @(negedge aclk);
    endtask

    // Feed ticks while the bus sequence runs or the receiver holds off;
    // otherwise let the results drain and look again.
    task automatic run_sequence(input int unsigned zero_pct, input bit noisy);
        logic [2:0] op;
        while (pending_count != 0 || last_busy) begin
            if (last_busy || rx_holding) begin
                op = OP_TICK;
                if (noisy && $urandom_range(0, 99) < 4) op = 3'($urandom_range(0, 7));
                send_item(op, 8'($urandom), 1'($urandom), $urandom_range(0, 99) >= zero_pct);
            end else begin
                s_valid <= 1'b0;
                @(negedge aclk);
            end
        end
    endtask

    task automatic cfg_write(input logic idx, input logic [CFG_W-1:0] val);
        cfg_index <= idx;
        cfg_data  <= val;
        cfg_we    <= 1'b1;
        @(negedge aclk);
        cfg_we    <= 1'b0;
        @(negedge aclk);
    endtask

    task automatic configure(input int unsigned tpu, input int unsigned tmo,
                             input int unsigned sgap, input int unsigned rgap,
                             input int unsigned hold);
        run_sequence(50, 1'b0);
        s_valid <= 1'b0;
        @(posedge aclk);
        recv_gap_max = rgap;
        rx_hold_len = hold;
        repeat (4) @(negedge aclk);
        send_gap_max = sgap;
        cfg_write(CFG_TICKS_PER_UNIT, CFG_W'(tpu));
        cfg_write(CFG_ACK_TIMEOUT, {8'($urandom), 8'(tmo)});
    endtask

    // result side: random stalls, one long hold-off on request
    initial begin
        int unsigned n;
        m_ready = 1'b0;
        last_busy = 1'b0;
        rx_holding = 1'b0;
        wait (aresetn === 1'b1);
        @(negedge aclk);
        forever begin
            n = $urandom_range(0, recv_gap_max);
            if (rx_hold_len != 0) begin
                n = rx_hold_len;
                rx_hold_len = 0;
                rx_holding = 1'b1;
            end
            if (n != 0) begin
                m_ready <= 1'b0;
                repeat (n) @(negedge aclk);
            end
            rx_holding = 1'b0;
            m_ready <= 1'b1;
            do @(posedge aclk); while (!m_valid);
            last_busy = m_busy_res;
            @(negedge aclk);
        end
    end

    initial begin
        int unsigned tpu_set[6];
        int unsigned tmo_set[6];
        int unsigned zero_sel[4];
        int          target;
        tpu_set  = '{1, 2, 0, 1, 3, 1};
        tmo_set  = '{255, 1, 4, 250, 2, 12};
        zero_sel = '{0, 3, 25, 60};
        aresetn      = 1'b0;
        cfg_we       = 1'b0;
        cfg_index    = CFG_TICKS_PER_UNIT;
        cfg_data     = '0;
        s_valid      = 1'b0;
        s_opcode     = OP_TICK;
        s_tx_byte    = '0;
        s_send_ack   = 1'b0;
        s_sda_sample = 1'b0;
        repeat (7) @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        // reset settings: reserved opcode, idle tick, a full start condition
        send_item(OP_RSVD, 8'hFF, 1'b1, 1'b1);
        send_item(OP_TICK, 8'h00, 1'b0, 1'b1);
        send_item(OP_START, 8'h5A, 1'b1, 1'b0);
        run_sequence(50, 1'b0);

        // zero ticks per unit behaves as one; shortest timeout
        configure(0, 1, 15, 15, 0);
        send_item(OP_WRITE, 8'h00, 1'b0, 1'b0);
        run_sequence(50, 1'b0);
        send_item(OP_WRITE, 8'hFF, 1'b1, 1'b1);
        send_item(OP_START, 8'h00, 1'b0, 1'b0);
        send_item(OP_RSVD, 8'h00, 1'b0, 1'b0);
        run_sequence(50, 1'b0);
        send_item(OP_READ, 8'h00, 1'b1, 1'b0);
        run_sequence(0, 1'b0);
        send_item(OP_READ, 8'hFF, 1'b0, 1'b1);
        run_sequence(100, 1'b0);
        send_item(OP_WAIT, 8'h00, 1'b0, 1'b0);
        run_sequence(0, 1'b0);
        send_item(OP_WAIT, 8'hFF, 1'b1, 1'b1);
        run_sequence(100, 1'b0);
        send_item(OP_CHECK, 8'hFF, 1'b1, 1'b1);
        run_sequence(0, 1'b0);
        send_item(OP_CHECK, 8'h00, 1'b0, 1'b0);
        run_sequence(100, 1'b0);
        send_item(OP_STOP, 8'hA5, 1'b1, 1'b0);
        run_sequence(50, 1'b0);

        // random command sequences with noise, one setting per pass
        for (int p = 0; p < 6; p++) begin
            configure(tpu_set[p], tmo_set[p], (p % 3 == 1 || p == 0) ? 0 : 15,
                      (p % 3 == 2) ? 0 : 15, (p == 0) ? 400 : 0);
            target = work_items + 190;
            while (work_items < target) begin
                if ($urandom_range(0, 9) == 0) begin
                    send_item(3'($urandom_range(0, 7)), 8'($urandom), 1'($urandom),
                              1'($urandom));
                end else begin
                    send_item(3'($urandom_range(OP_START, OP_CHECK)), 8'($urandom),
                              1'($urandom), 1'($urandom));
                    run_sequence(zero_sel[$urandom_range(0, 3)], 1'b1);
                end
            end
        end

        // long unit: many counts of the tick counter
        configure(24, 3, 0, 0, 0);
        send_item(OP_WAIT, 8'($urandom), 1'($urandom), 1'b0);
        run_sequence(100, 1'b0);

        s_valid <= 1'b0;
        while (pending_count != 0) @(negedge aclk);
        repeat (8) @(negedge aclk);
        if (fail_count == 0 && pending_count == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("RESULT: ERROR");
        end
        $finish;
    end

endmodule
